@@ hw/rtl/bulk_transfer_receiver_macros.svh @@
// Assertion shorthands shared by btr_core and btr_res_fifo.
// All of them sample on clk_i and stay quiet while rst_ni is low.
`ifndef BULK_TRANSFER_RECEIVER_MACROS_SVH
`define BULK_TRANSFER_RECEIVER_MACROS_SVH

// Plain invariant.
`define BTR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define BTR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BTR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/btr_pkg.sv @@
package btr_pkg;

  typedef enum logic [1:0] {
    REQ_CMD  = 2'd0,
    REQ_DATA = 2'd1,
    REQ_CONN = 2'd2,
    REQ_DISC = 2'd3
  } btr_req_e;

  typedef enum logic [1:0] {
    CODE_START_ACK    = 2'd0,
    CODE_DATA_ACK     = 2'd1,
    CODE_COMPLETE_ACK = 2'd2,
    CODE_NACK         = 2'd3
  } btr_code_e;

  typedef enum logic {
    KIND_NOTIFY  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } btr_kind_e;

  typedef enum logic [1:0] {
    CFG_TYPE_A = 2'd0,
    CFG_TYPE_B = 2'd1,
    CFG_TYPE_C = 2'd2,
    CFG_PPR    = 2'd3
  } btr_cfg_idx_e;

  localparam logic [7:0]  CMD_START    = 8'h01;
  localparam logic [7:0]  CMD_COMPLETE = 8'h03;
  localparam logic [3:0]  FRAME_LEN    = 4'd7;
  localparam logic [3:0]  CRC_LEN      = 4'd5;
  localparam logic [3:0]  POS_SAT      = 4'd8;
  localparam logic [3:0]  MIN_NACK_LEN = 4'd3;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam int unsigned FRAME_BYTES  = 7;

  localparam logic [7:0] TYPE_A_RST = 8'hA1;
  localparam logic [7:0] TYPE_B_RST = 8'hA2;
  localparam logic [7:0] TYPE_C_RST = 8'hA3;
  localparam logic [3:0] PPR_RST    = 4'd10;

  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  typedef struct packed {
    logic [7:0] type_a;
    logic [7:0] type_b;
    logic [7:0] type_c;
    logic [3:0] ppr;
  } btr_cfg_t;

  typedef struct packed {
    btr_kind_e  kind;
    btr_code_e  code;
    logic [7:0] typ;
    logic [7:0] id;
    logic [7:0] pay;
    logic       last;
  } btr_res_t;

  // CRC-16/MODBUS, one byte, reflected polynomial.
  function automatic logic [15:0] btr_crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/btr_core.sv @@
`include "bulk_transfer_receiver_macros.svh"

module btr_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           fire_i,
  input  btr_pkg::btr_req_e              req_i,
  input  logic [7:0]                     byte_i,
  input  logic                           last_i,
  input  btr_pkg::btr_cfg_t              cfg_i,
  output btr_pkg::btr_res_t [1:0]        res_o,
  output logic [1:0]                     res_cnt_o
);
  import btr_pkg::*;

  logic        active_q, active_d;
  logic [7:0]  cur_type_q, cur_type_d;
  logic [7:0]  cur_id_q, cur_id_d;
  logic [15:0] exp_q, exp_d;
  logic [15:0] recv_q, recv_d;
  logic [3:0]  rc_q, rc_d;
  logic        ovf_q, ovf_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  fields_q [FRAME_BYTES];
  logic [7:0]  fields_d [FRAME_BYTES];
  logic [15:0] crc_q, crc_d;
  logic        drop_q, drop_d;

  logic        nack_ovf, pay_en, ack, cmd_vld, drop, crc_ok, type_ok;
  logic [3:0]  rc;
  btr_code_e   cmd_code;
  logic [15:0] total, sent;

  always_comb begin
    active_d   = active_q;
    cur_type_d = cur_type_q;
    cur_id_d   = cur_id_q;
    exp_d      = exp_q;
    recv_d     = recv_q;
    rc_d       = rc_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    fields_d   = fields_q;
    crc_d      = crc_q;
    drop_d     = drop_q;
    nack_ovf   = 1'b0;
    pay_en     = 1'b0;
    ack        = 1'b0;
    cmd_vld    = 1'b0;
    cmd_code   = CODE_NACK;
    drop       = drop_q;
    rc         = rc_q;
    total      = 16'd0;
    sent       = 16'd0;
    crc_ok     = 1'b0;
    type_ok    = 1'b0;
    res_o      = '0;
    res_cnt_o  = 2'd0;

    if (req_i == REQ_CONN || req_i == REQ_DISC) begin
      // drop transfer and packet in progress
      active_d   = 1'b0;
      cur_type_d = 8'd0;
      cur_id_d   = 8'd0;
      exp_d      = 16'd0;
      recv_d     = 16'd0;
      rc_d       = 4'd0;
      ovf_d      = 1'b0;
      pos_d      = 4'd0;
      crc_d      = CRC_INIT;
      drop_d     = 1'b0;
    end else begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        if (pos_q == 4'(i)) fields_d[i] = byte_i;
      end
      if (pos_q < CRC_LEN) crc_d = btr_crc_byte(crc_q, byte_i);
      if (pos_q < POS_SAT) pos_d = pos_q + 4'd1;

      if (req_i == REQ_DATA) begin
        if (pos_q == 4'd0) begin
          drop = !active_q;
          if (active_q && recv_q >= exp_q) begin
            drop = 1'b1;
            if (!ovf_q) begin
              nack_ovf = 1'b1;
              ovf_d    = 1'b1;
            end
          end
        end
        drop_d = drop;
        if (active_q && !drop && recv_q < exp_q) begin
          pay_en = 1'b1;
          recv_d = recv_q + 16'd1;
        end
        if (last_i && active_q && !drop) begin
          rc = rc_q + 4'd1;
          if (rc >= cfg_i.ppr) begin
            ack = 1'b1;
            rc  = 4'd0;
          end
          rc_d = rc;
          if (recv_d >= exp_q) ack = 1'b1;
        end
      end else if (last_i) begin
        total   = {fields_d[3], fields_d[4]};
        sent    = {fields_d[6], fields_d[5]};
        crc_ok  = (crc_d == sent);
        type_ok = (fields_d[1] == cfg_i.type_a) || (fields_d[1] == cfg_i.type_b) ||
                  (fields_d[1] == cfg_i.type_c);
        if (fields_d[0] == CMD_START || fields_d[0] == CMD_COMPLETE) begin
          if (pos_d != FRAME_LEN) begin
            cmd_vld = (pos_d >= MIN_NACK_LEN);
          end else if (fields_d[0] == CMD_START) begin
            cmd_vld = 1'b1;
            if (crc_ok && type_ok) begin
              cmd_code   = CODE_START_ACK;
              active_d   = 1'b1;
              cur_type_d = fields_d[1];
              cur_id_d   = fields_d[2];
              exp_d      = total;
              recv_d     = 16'd0;
              rc_d       = 4'd0;
              ovf_d      = 1'b0;
            end
          end else begin
            cmd_vld = 1'b1;
            if (active_q && fields_d[2] == cur_id_q && fields_d[1] == cur_type_q) begin
              // matching complete ends the transfer either way
              if (crc_ok && recv_q == total) cmd_code = CODE_COMPLETE_ACK;
              active_d   = 1'b0;
              cur_type_d = 8'd0;
              cur_id_d   = 8'd0;
              exp_d      = 16'd0;
              recv_d     = 16'd0;
              rc_d       = 4'd0;
              ovf_d      = 1'b0;
            end
          end
        end
      end

      if (last_i) begin
        pos_d  = 4'd0;
        crc_d  = CRC_INIT;
        drop_d = 1'b0;
      end
    end

    // order results: overflow nack, or payload then data ack, or data ack alone, or command answer
    if (nack_ovf) begin
      res_o[0].kind = KIND_NOTIFY;
      res_o[0].code = CODE_NACK;
      res_o[0].typ  = cur_type_q;
      res_o[0].id   = cur_id_q;
      res_o[0].last = 1'b1;
      res_cnt_o     = 2'd1;
    end else if (pay_en) begin
      res_o[0].kind = KIND_PAYLOAD;
      res_o[0].pay  = byte_i;
      res_o[0].last = !ack;
      res_cnt_o     = 2'd1;
      if (ack) begin
        res_o[1].kind = KIND_NOTIFY;
        res_o[1].code = CODE_DATA_ACK;
        res_o[1].typ  = cur_type_q;
        res_o[1].id   = cur_id_q;
        res_o[1].last = 1'b1;
        res_cnt_o     = 2'd2;
      end
    end else if (ack) begin
      res_o[0].kind = KIND_NOTIFY;
      res_o[0].code = CODE_DATA_ACK;
      res_o[0].typ  = cur_type_q;
      res_o[0].id   = cur_id_q;
      res_o[0].last = 1'b1;
      res_cnt_o     = 2'd1;
    end else if (cmd_vld) begin
      res_o[0].kind = KIND_NOTIFY;
      res_o[0].code = cmd_code;
      res_o[0].typ  = fields_d[1];
      res_o[0].id   = fields_d[2];
      res_o[0].last = 1'b1;
      res_cnt_o     = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cur_type_q <= 8'd0;
      cur_id_q   <= 8'd0;
      exp_q      <= 16'd0;
      recv_q     <= 16'd0;
      rc_q       <= 4'd0;
      ovf_q      <= 1'b0;
      pos_q      <= 4'd0;
      crc_q      <= CRC_INIT;
      drop_q     <= 1'b0;
    end else if (fire_i) begin
      active_q   <= active_d;
      cur_type_q <= cur_type_d;
      cur_id_q   <= cur_id_d;
      exp_q      <= exp_d;
      recv_q     <= recv_d;
      rc_q       <= rc_d;
      ovf_q      <= ovf_d;
      pos_q      <= pos_d;
      crc_q      <= crc_d;
      drop_q     <= drop_d;
    end
  end

  // every byte read back was written earlier in the same packet
  always_ff @(posedge clk_i) begin
    if (fire_i) fields_q <= fields_d;
  end

  `BTR_ASSERT(a_pos_sat, pos_q <= POS_SAT, "frame position past saturation")
  `BTR_ASSERT_IMP(a_recv_bound, active_q, recv_q <= exp_q, "received count beyond total")
  `BTR_ASSERT_IMP(a_pair_order, res_cnt_o == 2'd2,
                  (res_o[0].kind == KIND_PAYLOAD) && (res_o[1].code == CODE_DATA_ACK),
                  "two results not payload then data ack")

endmodule

@@ hw/rtl/btr_res_fifo.sv @@
`include "bulk_transfer_receiver_macros.svh"

module btr_res_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [1:0]                        push_cnt_i,
  input  btr_pkg::btr_res_t [1:0]           push_i,
  output logic                              room_o,
  output logic                              valid_o,
  input  logic                              ready_i,
  output btr_pkg::btr_res_t                 head_o
);
  import btr_pkg::*;

  btr_res_t             mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop     = (cnt_q != '0) && ready_i;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // take a new item only if both of its possible results fit
  assign room_o  = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + RES_PTR_W'(push_cnt_i);
    rd_d  = rd_q + RES_PTR_W'(pop);
    cnt_d = cnt_q + RES_CNT_W'(push_cnt_i) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push_i[0];
    if (push_cnt_i == 2'd2) mem_q[wr_q + RES_PTR_W'(1)] <= push_i[1];
  end

  `BTR_ASSERT(a_cnt_max, cnt_q <= RES_CNT_W'(RES_DEPTH), "result queue count overrun")
  `BTR_ASSERT_IMP(a_push_room, push_cnt_i != 2'd0, room_o, "push into full result queue")
  `BTR_ASSERT_NEXT(a_pop_dec, pop && push_cnt_i == 2'd0,
                   cnt_q == $past(cnt_q) - RES_CNT_W'(1), "pop did not shrink queue")

endmodule

@@ hw/rtl/bulk_transfer_receiver.sv @@
// Channel        | Dir | Handshake             | Payload
// ---------------+-----+-----------------------+-------------------------------------------
// s_axis (bytes) | in  | s_axis_tvalid/tready  | tdata: data_byte; tuser: req_type;
//                |     |                       | tlast: last_byte
// m_axis (result)| out | m_axis_tvalid/tready  | tdata: notify_code, notify_type, notify_id,
//                |     |                       | payload_byte; tuser: result_kind;
//                |     |                       | tlast: last_result
// cfg (registers)| in  | cfg_valid/cfg_ready   | cfg_index, cfg_data (always ready)
//
// One byte per cycle while the result queue has room: an input register feeds the
// frame/transfer logic, which pushes its results into a four-entry result queue in
// the same cycle. A result passes the input register and the result queue before
// it shows on m_axis. An item that yields two results (payload byte plus data ack)
// pushes both at once and m_axis takes them in turn; the result queue sets the rate then.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled m_axis fills the queue; s_axis keeps taking bytes while it has
// room for two more results.

module bulk_transfer_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] req_type
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] notify_code, [9:2] notify_type, [17:10] notify_id,
  // [25:18] payload_byte, [31:26] zero
  output logic [31:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o,   // [0] result_kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import btr_pkg::*;

  // configuration registers
  btr_cfg_t  cfg_q;

  // input register
  logic       in_vld_q;
  btr_req_e   in_req_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  logic              fire;
  logic              room;
  logic [1:0]        res_cnt;
  btr_res_t [1:0]    res;
  btr_res_t          head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_a <= TYPE_A_RST;
      cfg_q.type_b <= TYPE_B_RST;
      cfg_q.type_c <= TYPE_C_RST;
      cfg_q.ppr    <= PPR_RST;
    end else if (cfg_valid_i) begin
      case (btr_cfg_idx_e'(cfg_index_i))
        CFG_TYPE_A: cfg_q.type_a <= cfg_data_i;
        CFG_TYPE_B: cfg_q.type_b <= cfg_data_i;
        CFG_TYPE_C: cfg_q.type_c <= cfg_data_i;
        CFG_PPR:    cfg_q.ppr    <= cfg_data_i[3:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  // Process the held byte once the queue can take both possible results;
  // refill the input register in the same cycle.
  assign fire            = in_vld_q && room;
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  // payload of the input register: hold while stalled
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q  <= btr_req_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  btr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .req_i     (in_req_q),
    .byte_i    (in_byte_q),
    .last_i    (in_last_q),
    .cfg_i     (cfg_q),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  btr_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (fire ? res_cnt : 2'd0),
    .push_i     (res),
    .room_o     (room),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .head_o     (head)
  );

  assign m_axis_tdata_o = {6'd0, head.pay, head.id, head.typ, head.code};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.last;

endmodule

@@ test/bulk_transfer_receiver_checker.sv @@
`timescale 1ns / 1ps

module bulk_transfer_receiver_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_o,
  input  logic [0:0]  m_axis_tuser_o,
  input  logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          pending_o,
  output int          errors_o
);
  import btr_pkg::*;

  // Register copies
  logic [7:0] ty_a, ty_b, ty_c;
  logic [3:0] ppr;

  // Transfer state
  logic        xfer_active;
  logic [7:0]  xfer_type, xfer_id;
  logic [15:0] xfer_total, xfer_rcvd;
  logic [3:0]  round_cnt;
  logic        ovf_nacked;

  // Packet state
  logic [3:0]  pos;
  logic [7:0]  frame [FRAME_BYTES];
  logic [15:0] hcrc;
  logic        pkt_drop;

  // Notifications and sink bytes still owed by the block, oldest first
  btr_res_t outgoing_q [$];
  btr_res_t want, got;
  int       err_cnt = 0;

  function automatic logic [15:0] crc_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] v;
    v = c ^ {8'h00, b};
    repeat (8) v = (v >> 1) ^ (v[0] ? CRC_POLY : 16'h0000);
    return v;
  endfunction

  function automatic btr_res_t notice(btr_code_e code, logic [7:0] typ, logic [7:0] id);
    btr_res_t r;
    r      = '0;
    r.kind = KIND_NOTIFY;
    r.code = code;
    r.typ  = typ;
    r.id   = id;
    return r;
  endfunction

  function automatic string fmt_res(btr_res_t r);
    return $sformatf("kind=%0d code=%0d type=%02h id=%02h pay=%02h last=%0d",
                     r.kind, r.code, r.typ, r.id, r.pay, r.last);
  endfunction

  task automatic clear_xfer();
    xfer_active = 1'b0;
    xfer_type   = '0;
    xfer_id     = '0;
    xfer_total  = '0;
    xfer_rcvd   = '0;
    round_cnt   = '0;
    ovf_nacked  = 1'b0;
  endtask

  task automatic clear_pkt();
    pos      = '0;
    hcrc     = CRC_INIT;
    pkt_drop = 1'b0;
  endtask

  // Advance the state by one accepted byte and queue what it must produce.
  task automatic absorb_byte(logic [1:0] req, logic [7:0] b, logic last);
    btr_res_t    r [2];
    int          n;
    logic        first, ack, crc_ok;
    logic [7:0]  code, typ, id;
    logic [15:0] total, sent;
    n     = 0;
    first = (pos == 0);
    if (req == REQ_CONN || req == REQ_DISC) begin
      clear_xfer();
      clear_pkt();
      return;
    end
    if (pos < FRAME_LEN) frame[pos[2:0]] = b;
    if (pos < CRC_LEN) hcrc = crc_update(hcrc, b);
    if (pos < POS_SAT) pos++;

    if (req == REQ_DATA) begin
      if (first) begin
        pkt_drop = !xfer_active;
        if (xfer_active && xfer_rcvd >= xfer_total) begin
          pkt_drop = 1'b1;
          if (!ovf_nacked) begin
            r[n] = notice(CODE_NACK, xfer_type, xfer_id);
            n++;
            ovf_nacked = 1'b1;
          end
        end
      end
      if (xfer_active && !pkt_drop && xfer_rcvd < xfer_total) begin
        r[n]      = '0;
        r[n].kind = KIND_PAYLOAD;
        r[n].pay  = b;
        n++;
        xfer_rcvd++;
      end
      if (last && xfer_active && !pkt_drop) begin
        ack = 1'b0;
        round_cnt++;
        if (round_cnt >= ppr) begin
          ack       = 1'b1;
          round_cnt = '0;
        end
        if (xfer_rcvd >= xfer_total) ack = 1'b1;
        if (ack) begin
          r[n] = notice(CODE_DATA_ACK, xfer_type, xfer_id);
          n++;
        end
      end
    end else if (last) begin
      code   = frame[0];
      typ    = frame[1];
      id     = frame[2];
      total  = {frame[3], frame[4]};
      sent   = {frame[6], frame[5]};
      crc_ok = (hcrc == sent);
      if (code == CMD_START || code == CMD_COMPLETE) begin
        if (pos != FRAME_LEN) begin
          if (pos >= MIN_NACK_LEN) begin
            r[n] = notice(CODE_NACK, typ, id);
            n++;
          end
        end else if (code == CMD_START) begin
          if (!crc_ok || !(typ == ty_a || typ == ty_b || typ == ty_c)) begin
            r[n] = notice(CODE_NACK, typ, id);
          end else begin
            clear_xfer();
            xfer_active = 1'b1;
            xfer_type   = typ;
            xfer_id     = id;
            xfer_total  = total;
            r[n] = notice(CODE_START_ACK, typ, id);
          end
          n++;
        end else if (!xfer_active || id != xfer_id || typ != xfer_type) begin
          r[n] = notice(CODE_NACK, typ, id);
          n++;
        end else begin
          r[n] = notice((crc_ok && xfer_rcvd == total) ? CODE_COMPLETE_ACK : CODE_NACK,
                        typ, id);
          n++;
          clear_xfer();
        end
      end
    end

    if (last) clear_pkt();
    if (n > 0) r[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) outgoing_q.push_back(r[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ty_a = TYPE_A_RST;
      ty_b = TYPE_B_RST;
      ty_c = TYPE_C_RST;
      ppr  = PPR_RST;
      clear_xfer();
      clear_pkt();
      for (int i = 0; i < FRAME_BYTES; i++) frame[i] = '0;
      outgoing_q.delete();
      pending_o <= 0;
      errors_o  <= err_cnt;
    end else begin
      // Results first: none can stem from a byte taken at this same edge.
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.kind = btr_kind_e'(m_axis_tuser_o[0]);
        got.code = btr_code_e'(m_axis_tdata_o[1:0]);
        got.typ  = m_axis_tdata_o[9:2];
        got.id   = m_axis_tdata_o[17:10];
        got.pay  = m_axis_tdata_o[25:18];
        got.last = m_axis_tlast_o;
        if (outgoing_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] result with nothing owed: %s", $realtime, fmt_res(got));
        end else begin
          want = outgoing_q.pop_front();
          if (got.kind !== want.kind || got.code !== want.code || got.typ !== want.typ ||
              got.id !== want.id || got.pay !== want.pay || got.last !== want.last ||
              m_axis_tdata_o[31:26] !== 6'd0) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] result mismatch\n  expected %s\n  actual   %s pad=%02h",
                       $realtime, fmt_res(want), fmt_res(got), m_axis_tdata_o[31:26]);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (btr_cfg_idx_e'(cfg_index_i))
          CFG_TYPE_A: ty_a = cfg_data_i;
          CFG_TYPE_B: ty_b = cfg_data_i;
          CFG_TYPE_C: ty_c = cfg_data_i;
          CFG_PPR:    ppr  = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        absorb_byte(s_axis_tuser_i, s_axis_tdata_i, s_axis_tlast_i);
      pending_o <= outgoing_q.size();
      errors_o  <= err_cnt;
    end
  end

endmodule

@@ test/bulk_transfer_receiver_tb.sv @@
`timescale 1ns / 1ps

module bulk_transfer_receiver_tb;
  import btr_pkg::*;

  localparam int ITEM_TARGET   = 1050;
  localparam int PHASE_ITEMS   = 150;
  localparam int IDLE_LIMIT    = 2000;  // cycles with no transfer on any channel
  localparam int SETTLE_CYCLES = 8;     // covers the latency through input register and result queue with margin

  // Receiver stall modes
  localparam int RX_FREE   = 0;
  localparam int RX_CHOPPY = 1;
  localparam int RX_CHOKED = 2;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i     = '0;
  logic [7:0]  cfg_data_i      = '0;

  int chk_pending;
  int chk_errors;

  int n_sent      = 0;   // input transfers issued so far
  int burst_left  = 0;   // transfers left in the current sender burst
  int stall_left  = 0;
  int stall_mode  = RX_FREE;
  int idle_cycles = 0;

  // Supported type codes as last programmed, used to build accepted starts
  logic [7:0] type_a = TYPE_A_RST;
  logic [7:0] type_b = TYPE_B_RST;
  logic [7:0] type_c = TYPE_C_RST;

  bulk_transfer_receiver u_top (.*);

  bulk_transfer_receiver_checker u_chk (
    .*,
    .pending_o (chk_pending),
    .errors_o  (chk_errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: switch between free flow, random chop and heavy stall in
  // segments of random length so stalls land on every phase of the work.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(RX_FREE, RX_CHOKED);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      RX_FREE:   m_axis_tready_i <= 1'b1;
      RX_CHOPPY: m_axis_tready_i <= 1'($urandom_range(0, 1));
      default:   m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: give up once no channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Drive one byte and hold it until the block takes it. Between bursts drop
  // tvalid for a random gap; a burst that continues keeps tvalid high.
  task automatic send_byte(logic [1:0] req, logic [7:0] b, logic last);
    if (burst_left == 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 48);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    n_sent++;
  endtask

  // One packet of random bytes on a single channel, tlast on the final byte.
  task automatic send_run(logic [1:0] req, int len);
    for (int i = 0; i < len; i++) send_byte(req, 8'($urandom), i == len - 1);
  endtask

  // Seven-byte command frame: code, type, id, total high, total low, then the
  // CRC-16/MODBUS of the first five bytes, low byte first.
  task automatic send_frame(logic [7:0] code, logic [7:0] typ, logic [7:0] id,
                            logic [15:0] total, logic bad_crc);
    logic [7:0]  hdr [7];
    logic [15:0] crc;
    hdr[0] = code;
    hdr[1] = typ;
    hdr[2] = id;
    hdr[3] = total[15:8];
    hdr[4] = total[7:0];
    crc = CRC_INIT;
    for (int i = 0; i < 5; i++) begin
      crc ^= {8'h00, hdr[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(0, 15));
    hdr[5] = crc[7:0];
    hdr[6] = crc[15:8];
    for (int i = 0; i < 7; i++) send_byte(REQ_CMD, hdr[i], i == 6);
  endtask

  // Hold the sender until every owed result has come out, then let any
  // result-free byte still in the pipe drain as well.
  task automatic pause_until_drained();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (chk_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(btr_cfg_idx_e idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // A mostly well-formed transfer with random content: start, data packets up to
  // the total, sometimes an overflow, then a complete that mostly matches.
  task automatic run_transfer();
    logic [7:0]  typ, id;
    logic [15:0] total;
    int          pushed, len, tiny;
    case ($urandom_range(0, 2))
      0:       typ = type_a;
      1:       typ = type_b;
      default: typ = type_c;
    endcase
    id = 8'($urandom);
    case ($urandom_range(0, 9))
      0:       total = '0;
      1:       total = {8'($urandom_range(1, 255)), 8'($urandom)};  // never reached
      2, 3, 4: total = 16'($urandom_range(1, 6));
      default: total = 16'($urandom_range(7, 40));
    endcase
    if ($urandom_range(0, 7) == 0) send_byte(REQ_CONN, 8'($urandom), 1'($urandom));
    send_frame(CMD_START, typ, id, total, $urandom_range(0, 15) == 0);

    // Mostly one- and two-byte packets now and then, to reach long rounds
    tiny   = $urandom_range(0, 1);
    pushed = 0;
    while (pushed < total && pushed < 60) begin
      len = tiny ? $urandom_range(1, 2) : $urandom_range(1, 8);
      send_run(REQ_DATA, len);
      pushed += len;
      if ($urandom_range(0, 39) == 0) send_byte(REQ_DISC, 8'($urandom), 1'($urandom));
      if ($urandom_range(0, 29) == 0) send_run(REQ_CMD, $urandom_range(1, 4));
    end
    // Overflow packets: only the first one past the total draws a NACK
    if (total == 0 || $urandom_range(0, 3) == 0) send_run(REQ_DATA, $urandom_range(1, 4));
    if ($urandom_range(0, 5) == 0) send_run(REQ_DATA, 1);

    case ($urandom_range(0, 9))
      0:       id ^= 8'($urandom_range(1, 255));
      1:       typ ^= 8'($urandom_range(1, 255));
      2:       total += 16'd1;
      default: ;
    endcase
    send_frame(CMD_COMPLETE, typ, id, total, $urandom_range(0, 9) == 0);
  endtask

  // Broken and stray traffic around the well-formed transfers.
  task automatic send_noise();
    int         len;
    logic [7:0] code;
    case ($urandom_range(0, 6))
      0: begin
        // Mixed channels, random packet ends, always closed at the end
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++)
          send_byte(2'($urandom_range(REQ_CMD, REQ_DATA)), 8'($urandom),
                    (i == len - 1) || ($urandom_range(0, 7) == 0));
      end
      1: begin
        // Start or complete code in a packet of one to ten bytes, longer than a frame too
        code = $urandom_range(0, 1) ? CMD_START : CMD_COMPLETE;
        len  = $urandom_range(1, 10);
        send_byte(REQ_CMD, code, len == 1);
        if (len > 1) send_run(REQ_CMD, len - 1);
      end
      2: send_frame(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 1'b0);
      3: send_frame(CMD_START, 8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)), 1'b0);
      4: send_frame(CMD_START, type_b, 8'($urandom), 16'($urandom_range(0, 20)), 1'b1);
      5: begin
        // Data while no transfer is open
        send_byte(REQ_DISC, 8'($urandom), 1'($urandom));
        send_run(REQ_DATA, $urandom_range(1, 5));
      end
      default: send_byte(2'($urandom_range(REQ_CONN, REQ_DISC)), 8'($urandom), 1'($urandom));
    endcase
  endtask

  initial begin
    logic [7:0] a, b, c, p;
    int         phase, next_phase_at;
    phase         = 0;
    next_phase_at = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed pass on reset settings: connect, start with a total of three,
    // bytes at both extremes, excess byte dropped with the closing data ACK,
    // one overflow NACK, matching complete, short start packet, disconnect.
    send_byte(REQ_CONN, 8'hFF, 1'b1);
    send_frame(CMD_START, TYPE_A_RST, 8'h00, 16'd3, 1'b0);
    send_byte(REQ_DATA, 8'h00, 1'b0);
    send_byte(REQ_DATA, 8'hFF, 1'b1);
    send_byte(REQ_DATA, 8'h5A, 1'b0);
    send_byte(REQ_DATA, 8'hA5, 1'b1);
    send_byte(REQ_DATA, 8'h3C, 1'b1);
    send_frame(CMD_COMPLETE, TYPE_A_RST, 8'h00, 16'd3, 1'b0);
    send_byte(REQ_CMD, CMD_START, 1'b0);
    send_byte(REQ_CMD, 8'h12, 1'b0);
    send_byte(REQ_CMD, 8'h34, 1'b1);
    send_byte(REQ_DISC, 8'h00, 1'b0);

    while (n_sent < ITEM_TARGET) begin
      if (n_sent >= next_phase_at) begin
        // Reprogram only with the block idle; extremes in the early phases
        pause_until_drained();
        case (phase)
          0: begin a = 8'h00;       b = 8'hFF;       c = 8'h5A;       p = 8'h01; end
          1: begin a = TYPE_A_RST;  b = TYPE_B_RST;  c = TYPE_C_RST;  p = 8'h0F; end
          2: begin a = 8'($urandom); b = 8'($urandom); c = 8'($urandom); p = 8'h00; end
          default: begin
            a = 8'($urandom);
            b = 8'($urandom);
            c = ($urandom_range(0, 3) == 0) ? a : 8'($urandom);
            p = 8'($urandom);
          end
        endcase
        write_cfg(CFG_TYPE_A, a);
        write_cfg(CFG_TYPE_B, b);
        write_cfg(CFG_TYPE_C, c);
        write_cfg(CFG_PPR, p);
        @(negedge clk_i);
        cfg_valid_i <= 1'b0;
        type_a = a;
        type_b = b;
        type_c = c;
        phase++;
        next_phase_at += PHASE_ITEMS;
      end
      case ($urandom_range(0, 19))
        0:             pause_until_drained();
        1, 2, 3, 4, 5: send_noise();
        default:       run_transfer();
      endcase
    end

    pause_until_drained();
    if (chk_errors == 0 && chk_pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
